>>> hdl/rlcfb_pkg.sv
// Shared types and constants for the LED chain frame builder.
package rlcfb_pkg;

  localparam logic [7:0] LedHeaderByte  = 8'hFF;
  localparam logic [7:0] EndFillByte    = 8'hFF;
  localparam logic [7:0] StartZeroByte  = 8'h00;
  localparam logic [2:0] StartZeroCount = 3'd4;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [3:0] {
    HUE_OFF    = 4'd0,
    HUE_RED    = 4'd1,
    HUE_GREEN  = 4'd2,
    HUE_BLUE   = 4'd3,
    HUE_YELLOW = 4'd4,
    HUE_PURPLE = 4'd5,
    HUE_CYAN   = 4'd6,
    HUE_AMBER  = 4'd7,
    HUE_WHITE  = 4'd8
  } color_t;

  // Position of a byte within the LED block.
  typedef enum logic [4:0] {
    SLOT_HEADER = 5'd0,
    SLOT_BLUE   = 5'd1,
    SLOT_GREEN  = 5'd2,
    SLOT_RED    = 5'd3
  } slot_t;

  // One LED job handed from front to back.
  typedef struct packed {
    logic       start;    // four zero bytes lead the LED
    logic       last_led; // end frame follows
    logic [4:0] fill;     // number of end fill bytes
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_job_t;

endpackage

>>> hdl/rlcfb_front.sv
// Front end: config register, chain position, color decode into LED jobs.
module rlcfb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [3:0]         color_code,
  input  logic [7:0]         brightness,
  input  logic               chain_length_we,
  input  logic [7:0]         chain_length,
  output rlcfb_pkg::led_job_t job
);
  import rlcfb_pkg::*;

  logic [7:0] length_reg;
  logic [7:0] led_position;
  logic [7:0] len;
  logic [8:0] fill_sum;
  logic       r_on, g_on, b_on;
  logic       last_led;

  always_comb begin
    r_on = 1'b0;
    g_on = 1'b0;
    b_on = 1'b0;
    unique case (color_code)
      HUE_RED:               r_on = 1'b1;
      HUE_GREEN:             g_on = 1'b1;
      HUE_BLUE:              b_on = 1'b1;
      HUE_YELLOW, HUE_AMBER: begin
        r_on = 1'b1;
        g_on = 1'b1;
      end
      HUE_PURPLE: begin
        r_on = 1'b1;
        b_on = 1'b1;
      end
      HUE_CYAN: begin
        g_on = 1'b1;
        b_on = 1'b1;
      end
      HUE_WHITE: begin
        r_on = 1'b1;
        g_on = 1'b1;
        b_on = 1'b1;
      end
      default: ;
    endcase
  end

  // zero length behaves as a single LED
  assign len      = (length_reg == 8'd0) ? 8'd1 : length_reg;
  assign last_led = ({1'b0, led_position} + 9'd1) >= {1'b0, len};
  assign fill_sum = {1'b0, len} + 9'd14;

  always_comb begin
    job.start    = (led_position == 8'd0);
    job.last_led = last_led;
    job.fill     = last_led ? fill_sum[8:4] : 5'd0;
    job.blue     = b_on ? brightness : 8'd0;
    job.green    = g_on ? brightness : 8'd0;
    job.red      = r_on ? brightness : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg   <= 8'd1;
      led_position <= 8'd0;
    end else begin
      if (chain_length_we) begin
        length_reg <= chain_length;
      end
      if (accept) begin
        led_position <= last_led ? 8'd0 : led_position + 8'd1;
      end
    end
  end

endmodule

>>> hdl/rlcfb_queue.sv
// Two-entry job queue between front and back.
module rlcfb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  rlcfb_pkg::led_job_t wr_job,
  input  logic                rd,
  output rlcfb_pkg::led_job_t head,
  output logic                head_valid,
  output logic                full
);
  import rlcfb_pkg::*;

  led_job_t   slots [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'(QueueDepth));

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      unique case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/rlcfb_back.sv
// Back end: walks the head job byte by byte into the output register.
module rlcfb_back (
  input  logic                clk,
  input  logic                rst,
  input  rlcfb_pkg::led_job_t head,
  input  logic                head_valid,
  output logic                head_done,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          wire_byte,
  output logic                run_last,
  output logic                frame_done
);
  import rlcfb_pkg::*;

  logic [4:0] byte_idx;
  logic [4:0] offset;
  logic [4:0] slot;
  logic [4:0] last_idx;
  logic [7:0] byte_val;
  logic       out_valid;
  logic       emit;
  logic       at_last;

  assign offset   = head.start ? {2'b00, StartZeroCount} : 5'd0;
  assign slot     = byte_idx - offset;
  assign last_idx = offset + 5'd3 + head.fill;
  assign at_last  = (byte_idx == last_idx);
  assign emit      = head_valid && (!out_valid || pop);
  assign head_done = emit && at_last;
  assign empty     = !out_valid;

  always_comb begin
    if (byte_idx < offset) begin
      byte_val = StartZeroByte;
    end else begin
      unique case (slot)
        SLOT_HEADER: byte_val = LedHeaderByte;
        SLOT_BLUE:   byte_val = head.blue;
        SLOT_GREEN:  byte_val = head.green;
        SLOT_RED:    byte_val = head.red;
        default:     byte_val = EndFillByte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      wire_byte  <= byte_val;
      run_last   <= at_last;
      frame_done <= at_last && head.last_led;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= 5'd0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        byte_idx <= at_last ? 5'd0 : byte_idx + 5'd1;
      end
    end
  end

endmodule

>>> hdl/rgb_led_chain_frame_builder_core.sv
// Top level of the LED chain frame builder: front, job queue and back.
// The first word of an item passes through the job queue and then the output register.
// Each LED gives 4 words, plus 4 leading zero words on the first LED of
// a frame and (length+14)/16 fill words on the last; the back sequencer
// gives one word per cycle while the receiver pops, fed by a two-job queue.
// Reset (rst, synchronous): queue and output empty, position 0, length 1.
module rgb_led_chain_frame_builder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [3:0] color_code,
  input  logic [7:0] brightness,
  input  logic       chain_length_we,
  input  logic [7:0] chain_length,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] wire_byte,
  output logic       run_last,
  output logic       frame_done
);
  import rlcfb_pkg::*;

  led_job_t new_job;
  led_job_t head;
  logic     head_valid;
  logic     head_done;
  logic     accept;

  assign accept = push && !full;

  rlcfb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .color_code      (color_code),
    .brightness      (brightness),
    .chain_length_we (chain_length_we),
    .chain_length    (chain_length),
    .job             (new_job)
  );

  rlcfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (accept),
    .wr_job     (new_job),
    .rd         (head_done),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  rlcfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_done  (head_done),
    .pop        (pop),
    .empty      (empty),
    .wire_byte  (wire_byte),
    .run_last   (run_last),
    .frame_done (frame_done)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the LED chain frame builder: table, random frames, stalls.
module tb;
  import rlcfb_pkg::*;

  localparam logic [3:0] ColorUnknownLo = 4'd9;
  localparam logic [3:0] ColorUnknownHi = 4'd15;
  localparam int NumRows = 21;

  // One output word as the chain sees it.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       frame_end;
  } word_t;

  // One stimulus row; channel bytes and framing are typed in where known.
  typedef struct packed {
    bit         cfg;
    logic [7:0] cfg_len;
    logic [3:0] color;
    logic [7:0] level;
    bit         known;
    bit         lead;
    bit         ends;
    logic [4:0] fill;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_row_t;

  // cfg, len, color, level, known, lead, ends, fill, blue, green, red
  localparam led_row_t Rows [NumRows] = '{
    '{1'b0, 8'd0, HUE_OFF,        8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, HUE_RED,        8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'h00, 8'hFF},
    '{1'b0, 8'd0, HUE_GREEN,      8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'hFF, 8'h00},
    '{1'b0, 8'd0, HUE_BLUE,       8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 8'hFF, 8'h00, 8'h00},
    '{1'b0, 8'd0, HUE_YELLOW,     8'hAA, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'hAA, 8'hAA},
    '{1'b0, 8'd0, HUE_PURPLE,     8'h55, 1'b1, 1'b1, 1'b1, 5'd0, 8'h55, 8'h00, 8'h55},
    '{1'b0, 8'd0, HUE_CYAN,       8'h01, 1'b1, 1'b1, 1'b1, 5'd0, 8'h01, 8'h01, 8'h00},
    '{1'b0, 8'd0, HUE_AMBER,      8'h80, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'h80, 8'h80},
    '{1'b0, 8'd0, HUE_WHITE,      8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 8'hFF, 8'hFF, 8'hFF},
    '{1'b0, 8'd0, HUE_WHITE,      8'h00, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, ColorUnknownLo, 8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, ColorUnknownHi, 8'hFF, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'h00, 8'h00},
    // zero length behaves as a single LED
    '{1'b1, 8'd0, HUE_RED,        8'hC8, 1'b1, 1'b1, 1'b1, 5'd0, 8'h00, 8'h00, 8'hC8},
    '{1'b1, 8'd3, HUE_GREEN,      8'h07, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, HUE_BLUE,       8'h09, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, HUE_WHITE,      8'hFF, 1'b1, 1'b0, 1'b1, 5'd1, 8'hFF, 8'hFF, 8'hFF},
    '{1'b1, 8'd5, HUE_RED,        8'h01, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, HUE_RED,        8'h02, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, HUE_RED,        8'h03, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00},
    // length cut below the position: this LED closes the frame
    '{1'b1, 8'd2, HUE_CYAN,       8'hFF, 1'b1, 1'b0, 1'b1, 5'd1, 8'hFF, 8'hFF, 8'h00},
    '{1'b0, 8'd0, HUE_OFF,        8'h00, 1'b1, 1'b1, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [3:0] color_code;
  logic [7:0] brightness;
  logic       chain_length_we;
  logic [7:0] chain_length;
  logic       empty;
  logic       pop;
  logic [7:0] wire_byte;
  logic       run_last;
  logic       frame_done;

  led_row_t   shown_row;
  word_t      pending_words [$];
  logic [7:0] chain_pos;
  logic [7:0] frame_len;
  int         fail_count = 0;
  bit         tx_eager = 1'b0;
  bit         rx_eager = 1'b0;
  bit         squeeze_req = 1'b0;

  rgb_led_chain_frame_builder_core dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .color_code      (color_code),
    .brightness      (brightness),
    .chain_length_we (chain_length_we),
    .chain_length    (chain_length),
    .empty           (empty),
    .pop             (pop),
    .wire_byte       (wire_byte),
    .run_last        (run_last),
    .frame_done      (frame_done)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Channel selection and framing for one LED; advances the chain position.
  function automatic void encode_led(input logic [3:0] color, input logic [7:0] level,
                                     output bit lead, output bit ends,
                                     output logic [4:0] fill, output logic [7:0] blue,
                                     output logic [7:0] green, output logic [7:0] red);
    bit r_on, g_on, b_on;
    int eff_len;
    r_on = 1'b0;
    g_on = 1'b0;
    b_on = 1'b0;
    case (color)
      HUE_RED:               r_on = 1'b1;
      HUE_GREEN:             g_on = 1'b1;
      HUE_BLUE:              b_on = 1'b1;
      HUE_YELLOW, HUE_AMBER: begin r_on = 1'b1; g_on = 1'b1; end
      HUE_PURPLE:            begin r_on = 1'b1; b_on = 1'b1; end
      HUE_CYAN:              begin g_on = 1'b1; b_on = 1'b1; end
      HUE_WHITE:             begin r_on = 1'b1; g_on = 1'b1; b_on = 1'b1; end
      default:               ;
    endcase
    blue    = b_on ? level : 8'h00;
    green   = g_on ? level : 8'h00;
    red     = r_on ? level : 8'h00;
    eff_len = (frame_len == 8'd0) ? 1 : int'(frame_len);
    lead    = (chain_pos == 8'd0);
    ends    = (int'(chain_pos) + 1) >= eff_len;
    fill    = ends ? 5'((eff_len + 14) / 16) : 5'd0;
    chain_pos = ends ? 8'd0 : chain_pos + 8'd1;
  endfunction

  function automatic void queue_led_words(input bit lead, input bit ends,
                                          input logic [4:0] fill, input logic [7:0] blue,
                                          input logic [7:0] green, input logic [7:0] red);
    word_t burst [$];
    if (lead) begin
      for (int i = 0; i < int'(StartZeroCount); i++) begin
        burst.push_back(word_t'{StartZeroByte, 1'b0, 1'b0});
      end
    end
    burst.push_back(word_t'{LedHeaderByte, 1'b0, 1'b0});
    burst.push_back(word_t'{blue, 1'b0, 1'b0});
    burst.push_back(word_t'{green, 1'b0, 1'b0});
    burst.push_back(word_t'{red, 1'b0, 1'b0});
    for (int i = 0; i < int'(fill); i++) begin
      burst.push_back(word_t'{EndFillByte, 1'b0, 1'b0});
    end
    burst[burst.size() - 1].run_end   = 1'b1;
    burst[burst.size() - 1].frame_end = ends;
    foreach (burst[k]) pending_words.push_back(burst[k]);
  endfunction

  always @(posedge clk) begin : watch
    word_t      want;
    bit         lead, ends;
    logic [4:0] fill;
    logic [7:0] blue, green, red;
    if (rst) begin
      chain_pos = 8'd0;
      frame_len = 8'd1;
      pending_words.delete();
    end else begin
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: wire_byte %0h run_last %0b frame_done %0b",
                 wire_byte, run_last, frame_done);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (wire_byte !== want.data) begin
            $error("wire_byte: expected %0h, got %0h", want.data, wire_byte);
            fail_count++;
          end
          if (run_last !== want.run_end) begin
            $error("run_last: expected %0b, got %0b", want.run_end, run_last);
            fail_count++;
          end
          if (frame_done !== want.frame_end) begin
            $error("frame_done: expected %0b, got %0b", want.frame_end, frame_done);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        encode_led(color_code, brightness, lead, ends, fill, blue, green, red);
        if (shown_row.known) begin
          queue_led_words(shown_row.lead, shown_row.ends, shown_row.fill,
                          shown_row.blue, shown_row.green, shown_row.red);
        end else begin
          queue_led_words(lead, ends, fill, blue, green, red);
        end
      end
      if (chain_length_we) frame_len = chain_length;
    end
  end

  task automatic send_led(input led_row_t row);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push       <= 1'b1;
    color_code <= row.color;
    brightness <= row.level;
    shown_row  <= row;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stop offering and let every expected word come out.
  task automatic drain;
    @(negedge clk);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length(input logic [7:0] len);
    @(negedge clk);
    chain_length_we <= 1'b1;
    chain_length    <= len;
    @(negedge clk);
    chain_length_we <= 1'b0;
  endtask

  // Receiver: random stall per word, one long hold-off to back the block up.
  initial begin : drain_side
    int  stall;
    bit  squeezed;
    squeezed = 1'b0;
    pop = 1'b0;
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, 16);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        stall    = 300;
      end
      if (stall > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin : stim
    int       phase_len [8];
    int       len;
    int       count;
    led_row_t row;
    phase_len       = '{3, 1, 16, 17, 0, 255, 2, 0};
    rst             = 1'b1;
    push            = 1'b0;
    color_code      = 4'd0;
    brightness      = 8'd0;
    chain_length_we = 1'b0;
    chain_length    = 8'd0;
    shown_row       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumRows; i++) begin
      if (Rows[i].cfg) begin
        drain();
        set_length(Rows[i].cfg_len);
      end
      send_led(Rows[i]);
    end

    // Random frames; a new length may land mid-frame and cut it short.
    for (int p = 0; p < 8; p++) begin
      len = (p == 7) ? $urandom_range(1, 255) : phase_len[p];
      drain();
      set_length(8'(len));
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      count    = (len == 255) ? 40 : $urandom_range(10, 18);
      if (len == 255) begin
        tx_eager    = 1'b1;
        squeeze_req = 1'b1;
      end
      for (int n = 0; n < count; n++) begin
        row = '0;
        row.color = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 8))
                                                : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
          0:       row.level = 8'h00;
          1:       row.level = 8'hFF;
          default: row.level = 8'($urandom_range(0, 255));
        endcase
        send_led(row);
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
